// ----- rtl/itr4_pkg.sv -----
// Types and butterfly function for the 4x4 inverse transform and reconstruction.
// No dependencies; used by all modules of the core.
package itr4_pkg;

   localparam int RoundShift = 6;

   typedef logic [63:0] coef_row_type;  // four signed 16-bit values, column 0 low
   typedef logic [31:0] pix_row_type;   // four bytes, column 0 low

   typedef struct packed {
      coef_row_type [3:0] coef;
      pix_row_type [3:0] pred;
   } blk_type;

   // 1-D core butterfly, all terms wrap at 16 bits
   function automatic coef_row_type butterfly(input coef_row_type a);
      logic signed [15:0] a0, a1, a2, a3;
      logic signed [15:0] s0, d0, s1, d1;
      logic signed [15:0] y0, y1, y2, y3;
      a0 = a[15:0];
      a1 = a[31:16];
      a2 = a[47:32];
      a3 = a[63:48];
      s0 = a0 + a2;
      d0 = a0 - a2;
      s1 = a1 + (a3 >>> 1);
      d1 = (a1 >>> 1) - a3;
      y0 = s0 + s1;
      y1 = d0 + d1;
      y2 = d0 - d1;
      y3 = s0 - s1;
      return {y3, y2, y1, y0};
   endfunction

endpackage

// ----- rtl/itr4_row_pass.sv -----
// Horizontal transform stage: butterfly over each coefficient row, registered.
// Depends on itr4_pkg.
module itr4_row_pass import itr4_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  blk_type in_blk,
   output logic    out_valid,
   output blk_type out_blk
);

   logic    valid_ff;
   blk_type blk_ff, blk_in;

   always_comb begin
      blk_in.pred = in_blk.pred;
      for (int r = 0; r < 4; r++) begin
         blk_in.coef[r] = butterfly(in_blk.coef[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      blk_ff <= blk_in;
   end

   assign out_valid = valid_ff;
   assign out_blk   = blk_ff;

endmodule

// ----- rtl/itr4_col_pass.sv -----
// Vertical transform stage: butterfly over each column, registered.
// Depends on itr4_pkg.
module itr4_col_pass import itr4_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  blk_type in_blk,
   output logic    out_valid,
   output blk_type out_blk
);

   logic         valid_ff;
   blk_type      blk_ff, blk_in;
   coef_row_type col_v [4];
   coef_row_type col_y [4];

   always_comb begin
      blk_in.pred = in_blk.pred;
      for (int c = 0; c < 4; c++) begin
         col_v[c] = {in_blk.coef[3][16*c +: 16], in_blk.coef[2][16*c +: 16],
                     in_blk.coef[1][16*c +: 16], in_blk.coef[0][16*c +: 16]};
         col_y[c] = butterfly(col_v[c]);
      end
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            blk_in.coef[r][16*c +: 16] = col_y[c][16*r +: 16];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      blk_ff <= blk_in;
   end

   assign out_valid = valid_ff;
   assign out_blk   = blk_ff;

endmodule

// ----- rtl/itr4_recon.sv -----
// Reconstruction stage: rounding shift, prediction add, clip to 0..255, registered.
// Depends on itr4_pkg.
module itr4_recon import itr4_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  blk_type           in_blk,
   output logic              out_valid,
   output pix_row_type [3:0] out_pix
);

   localparam logic signed [16:0] RoundAdd = 17'sd1 <<< (RoundShift - 1);

   logic              valid_ff;
   pix_row_type [3:0] pix_ff, pix_in;
   logic signed [16:0] t, q, s;

   always_comb begin
      t = '0;
      q = '0;
      s = '0;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            t = {in_blk.coef[r][16*c + 15], in_blk.coef[r][16*c +: 16]} + RoundAdd;
            q = t >>> RoundShift;
            s = q + $signed({9'd0, in_blk.pred[r][8*c +: 8]});
            if (s < 0) begin
               pix_in[r][8*c +: 8] = 8'd0;
            end else if (s > 17'sd255) begin
               pix_in[r][8*c +: 8] = 8'd255;
            end else begin
               pix_in[r][8*c +: 8] = s[7:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      pix_ff <= pix_in;
   end

   assign out_valid = valid_ff;
   assign out_pix   = pix_ff;

endmodule

// ----- rtl/inverse_transform_reconstruct_4x4_core.sv -----
// 4x4 inverse integer transform with reconstruction, three register stages.
// A transaction taken on start passes the row, column and recon registers in turn before rsp_valid rises.
// Throughput: one transaction per cycle; busy stays low, the receiver cannot stall.
// Stages: row butterflies, column butterflies, round/add/clip.
// Reset (synchronous, active high) clears the stage valid bits only.
// Depends on itr4_pkg, itr4_row_pass, itr4_col_pass, itr4_recon.
module inverse_transform_reconstruct_4x4_core import itr4_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  coef_row_type req_coef_row0,
   input  coef_row_type req_coef_row1,
   input  coef_row_type req_coef_row2,
   input  coef_row_type req_coef_row3,
   input  pix_row_type  req_pred_row0,
   input  pix_row_type  req_pred_row1,
   input  pix_row_type  req_pred_row2,
   input  pix_row_type  req_pred_row3,
   output logic         rsp_valid,
   output pix_row_type  rsp_recon_row0,
   output pix_row_type  rsp_recon_row1,
   output pix_row_type  rsp_recon_row2,
   output pix_row_type  rsp_recon_row3
);

   blk_type           in_blk, row_blk, col_blk;
   logic              in_valid, row_valid, col_valid;
   pix_row_type [3:0] recon;

   assign busy     = 1'b0;
   assign in_valid = start & ~busy;

   assign in_blk.coef = {req_coef_row3, req_coef_row2, req_coef_row1, req_coef_row0};
   assign in_blk.pred = {req_pred_row3, req_pred_row2, req_pred_row1, req_pred_row0};

   itr4_row_pass u_row (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .in_blk    (in_blk),
      .out_valid (row_valid),
      .out_blk   (row_blk)
   );

   itr4_col_pass u_col (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (row_valid),
      .in_blk    (row_blk),
      .out_valid (col_valid),
      .out_blk   (col_blk)
   );

   itr4_recon u_recon (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (col_valid),
      .in_blk    (col_blk),
      .out_valid (rsp_valid),
      .out_pix   (recon)
   );

   assign rsp_recon_row0 = recon[0];
   assign rsp_recon_row1 = recon[1];
   assign rsp_recon_row2 = recon[2];
   assign rsp_recon_row3 = recon[3];

endmodule

// ----- rtl/itr4_checker.sv -----
// Port-level checks for the 4x4 inverse transform core, bound to the top level.
// Depends on itr4_pkg and inverse_transform_reconstruct_4x4_core.
module itr4_checker import itr4_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input coef_row_type req_coef_row0,
   input coef_row_type req_coef_row1,
   input coef_row_type req_coef_row2,
   input coef_row_type req_coef_row3,
   input pix_row_type  req_pred_row0,
   input logic         rsp_valid,
   input pix_row_type  rsp_recon_row0
);

   logic zero_coef;
   assign zero_coef = (req_coef_row0 == '0) && (req_coef_row1 == '0) &&
                      (req_coef_row2 == '0) && (req_coef_row3 == '0);

   a_busy_low: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 3))
      else $error("result without transaction");

   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid)
      else $error("transaction lost");

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result after reset");

   a_zero_passes_pred: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && zero_coef) |-> ##3 (rsp_recon_row0 == $past(req_pred_row0, 3)))
      else $error("zero residual altered prediction");

endmodule

bind inverse_transform_reconstruct_4x4_core itr4_checker u_itr4_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_coef_row0  (req_coef_row0),
   .req_coef_row1  (req_coef_row1),
   .req_coef_row2  (req_coef_row2),
   .req_coef_row3  (req_coef_row3),
   .req_pred_row0  (req_pred_row0),
   .rsp_valid      (rsp_valid),
   .rsp_recon_row0 (rsp_recon_row0)
);
